FILE: design/ohrr_pkg.sv
package ohrr_pkg;

  // Field widths
  localparam int CMD_W   = 3;
  localparam int SPD_W   = 16;
  localparam int YAW_W   = 16;
  localparam int SUM_W   = 17;
  localparam int GAIN_W  = 20;
  localparam int STEP_W  = 32;
  localparam int PROD_W  = SUM_W + GAIN_W;
  localparam int INC_W   = PROD_W - 1;
  localparam int ACC_W   = 40;
  localparam int ERR_W   = 16;
  localparam int NAV_W   = 2;
  localparam int IN_W    = 56;

  // Input field positions in in_tdata
  localparam int CMD_LSB   = 0;
  localparam int LEFT_LSB  = CMD_LSB + CMD_W;
  localparam int RIGHT_LSB = LEFT_LSB + SPD_W;
  localparam int YAW_LSB   = RIGHT_LSB + SPD_W;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MILEAGE_GAIN  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_DISTANCE = 1'b1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd28111;
  localparam logic [STEP_W-1:0] STEP_RESET = 32'd83886080;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START_RECORD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP_RECORD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START_REPLAY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START_STRAIGHT = 3'd4;

  typedef enum logic [NAV_W-1:0] {
    MODE_IDLE     = 2'd0,
    MODE_RECORD   = 2'd1,
    MODE_REPLAY   = 2'd2,
    MODE_STRAIGHT = 2'd3
  } mode_t;

  // Item handed from the odometry front end to the navigation core
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [YAW_W-1:0] yaw;
    logic [INC_W-1:0]        inc;
  } odo_item_t;

endpackage

FILE: design/ohrr_front.sv
module ohrr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ohrr_pkg::IN_W-1:0]     in_tdata,
  input  logic [ohrr_pkg::GAIN_W-1:0]   gain,
  output logic                          item_valid,
  input  logic                          item_ready,
  output ohrr_pkg::odo_item_t           item
);
  import ohrr_pkg::*;

  logic                     s1_v_r, s1_v_nxt;
  logic [CMD_W-1:0]         s1_cmd_r;
  logic signed [YAW_W-1:0]  s1_yaw_r;
  logic [SUM_W-1:0]         s1_sum_r;
  logic                     s2_v_r, s2_v_nxt;
  odo_item_t                s2_item_r;
  logic                     s2_load;
  logic [SPD_W-1:0]         left_w, right_w;
  logic [SUM_W-1:0]         left_mag, right_mag, speed_sum;
  logic [PROD_W-1:0]        prod;

  // Wheel speed magnitudes; the most negative speed needs the extra bit
  always_comb begin
    left_w    = in_tdata[LEFT_LSB +: SPD_W];
    right_w   = in_tdata[RIGHT_LSB +: SPD_W];
    left_mag  = left_w[SPD_W-1] ? SUM_W'(-{1'b1, left_w}) : SUM_W'(left_w);
    right_mag = right_w[SPD_W-1] ? SUM_W'(-{1'b1, right_w}) : SUM_W'(right_w);
    speed_sum = left_mag + right_mag;
  end

  // Distance increment for the item held in stage one
  assign prod = PROD_W'(s1_sum_r) * PROD_W'(gain);

  // Stage handshakes
  assign s2_load    = s1_v_r && (!s2_v_r || item_ready);
  assign in_tready  = !s1_v_r || s2_load;
  assign item_valid = s2_v_r;
  assign item       = s2_item_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_tvalid && in_tready) begin
      s1_v_nxt = 1'b1;
    end else if (s2_load) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s2_load) begin
      s2_v_nxt = 1'b1;
    end else if (item_ready) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Capture the item and its speed sum
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r <= in_tdata[CMD_LSB +: CMD_W];
      s1_yaw_r <= in_tdata[YAW_LSB +: YAW_W];
      s1_sum_r <= speed_sum;
    end
  end

  // Register the scaled increment
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_item_r.cmd <= s1_cmd_r;
      s2_item_r.yaw <= s1_yaw_r;
      s2_item_r.inc <= prod[PROD_W-1:1];
    end
  end

endmodule

FILE: design/ohrr_core.sv
module ohrr_core #(
  parameter int  RECORD_DEPTH = 8192,
  localparam int CNT_W = $clog2(RECORD_DEPTH + 1),
  localparam int OUT_W = ((ohrr_pkg::ERR_W + ohrr_pkg::NAV_W + CNT_W + 1 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  ohrr_pkg::odo_item_t           item,
  input  logic [ohrr_pkg::STEP_W-1:0]   step,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata
);
  import ohrr_pkg::*;

  localparam int IDX_W = $clog2(RECORD_DEPTH);

  logic signed [YAW_W-1:0] heading_mem [RECORD_DEPTH];

  mode_t                   mode_r, mode_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]        stored_r, stored_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic signed [YAW_W-1:0] target_r, target_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic                    done_r, done_nxt;
  logic signed [YAW_W-1:0] first_r, first_nxt;
  logic signed [YAW_W-1:0] rd_data_r;
  logic                    out_v_r, out_v_nxt;
  logic [OUT_W-1:0]        out_data_r;

  logic                    proc;
  logic [ACC_W:0]          acc_wide;
  logic [ACC_W-1:0]        acc_sum;
  logic                    step_hit;
  logic [ACC_W-1:0]        acc_left;
  logic                    last_point;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr, rd_addr;
  logic [NAV_W-1:0]        nav_nxt;

  // Wrap a heading difference into (-18000, 18000] centidegrees
  function automatic logic signed [ERR_W-1:0] wrap_cdeg(
    input logic signed [YAW_W-1:0] a,
    input logic signed [YAW_W-1:0] b
  );
    logic signed [YAW_W+1:0] d;
    d = {{2{a[YAW_W-1]}}, a} - {{2{b[YAW_W-1]}}, b};
    if (d > 18'sd18000) d = d - 18'sd36000;
    if (d > 18'sd18000) d = d - 18'sd36000;
    if (d <= -18'sd18000) d = d + 18'sd36000;
    if (d <= -18'sd18000) d = d + 18'sd36000;
    return d[ERR_W-1:0];
  endfunction

  assign item_ready = !out_v_r || out_tready;
  assign proc       = item_valid && item_ready;

  // Saturating odometry and step test
  always_comb begin
    acc_wide = {1'b0, acc_r} + (ACC_W + 1)'(item.inc);
    acc_sum  = acc_wide[ACC_W] ? {ACC_W{1'b1}} : acc_wide[ACC_W-1:0];
    step_hit = acc_sum >= ACC_W'(step);
    acc_left = acc_sum - ACC_W'(step);
    last_point = (stored_r == '0) || ((CNT_W'(pos_r) + CNT_W'(1)) >= stored_r);
  end

  // Next state for one item
  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    stored_nxt = stored_r;
    pos_nxt    = pos_r;
    target_nxt = target_r;
    err_nxt    = err_r;
    done_nxt   = done_r;
    first_nxt  = first_r;
    wr_en      = 1'b0;
    wr_addr    = stored_r[IDX_W-1:0];
    if (proc) begin
      case (item.cmd)
        CMD_TICK: begin
          case (mode_r)
            MODE_RECORD: begin
              acc_nxt = acc_sum;
              if (step_hit) begin
                acc_nxt = acc_left;
                // drop the sample once the store is full
                if (stored_r < CNT_W'(RECORD_DEPTH)) begin
                  wr_en      = 1'b1;
                  stored_nxt = stored_r + CNT_W'(1);
                  if (stored_r == '0) begin
                    first_nxt = item.yaw;
                  end
                end
              end
            end
            MODE_REPLAY: begin
              acc_nxt = acc_sum;
              if (!step_hit) begin
                err_nxt = wrap_cdeg(item.yaw, target_r);
              end else begin
                acc_nxt = acc_left;
                if (last_point) begin
                  done_nxt = 1'b1;
                  err_nxt  = '0;
                end else begin
                  pos_nxt    = pos_r + IDX_W'(1);
                  target_nxt = rd_data_r;
                  err_nxt    = wrap_cdeg(item.yaw, rd_data_r);
                end
              end
            end
            MODE_STRAIGHT: begin
              acc_nxt = acc_sum;
              err_nxt = wrap_cdeg(item.yaw, target_r);
            end
            default: begin
            end
          endcase
        end
        CMD_START_RECORD: begin
          stored_nxt = '0;
          pos_nxt    = '0;
          acc_nxt    = '0;
          target_nxt = '0;
          err_nxt    = '0;
          done_nxt   = 1'b0;
          mode_nxt   = MODE_RECORD;
        end
        CMD_STOP_RECORD: begin
          if (mode_r == MODE_RECORD) begin
            mode_nxt = MODE_IDLE;
          end
        end
        CMD_START_REPLAY: begin
          if (stored_r != '0) begin
            pos_nxt    = '0;
            acc_nxt    = '0;
            target_nxt = first_r;
            err_nxt    = '0;
            done_nxt   = 1'b0;
            mode_nxt   = MODE_REPLAY;
          end
        end
        CMD_START_STRAIGHT: begin
          pos_nxt    = '0;
          acc_nxt    = '0;
          target_nxt = item.yaw;
          err_nxt    = '0;
          done_nxt   = 1'b0;
          mode_nxt   = MODE_STRAIGHT;
        end
        default: begin
        end
      endcase
    end
    // prefetch the heading after the current replay position
    rd_addr = pos_nxt + IDX_W'(1);
    if (mode_nxt == MODE_REPLAY) begin
      nav_nxt = done_nxt ? MODE_IDLE : MODE_REPLAY;
    end else begin
      nav_nxt = mode_nxt;
    end
    out_v_nxt = out_v_r;
    if (proc) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      acc_r    <= '0;
      stored_r <= '0;
      pos_r    <= '0;
      target_r <= '0;
      err_r    <= '0;
      done_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      stored_r <= stored_nxt;
      pos_r    <= pos_nxt;
      target_r <= target_nxt;
      err_r    <= err_nxt;
      done_r   <= done_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Copy of the first stored heading, read when replay starts
  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

  // Heading store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heading_mem[wr_addr] <= item.yaw;
    end
    rd_data_r <= heading_mem[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= OUT_W'({done_nxt, stored_nxt, nav_nxt, err_nxt});
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: design/odometry_heading_record_replay_top.sv
// Teach-and-repeat heading navigator. Each input item is a tick or a mode
// command; every item yields exactly one result item with the held heading
// error, navigation state, number of stored headings and the replay-done flag.
// The block takes one item per clock cycle while result items are taken.
// The wheel speed sum is registered on acceptance, then the mileage
// product, and then the state update lands in the result register.
// The heading store is a RECORD_DEPTH x 16 memory with one write and one
// registered read port; the read port prefetches the next replay heading,
// so replay steps on consecutive items need no stall. Never-written store
// entries are not cleared and their read data is never used. Configuration
// writes take effect at once and are meant for idle periods only.
module odometry_heading_record_replay_top #(
  parameter int  RECORD_DEPTH = 8192,
  localparam int CNT_W = $clog2(RECORD_DEPTH + 1),
  localparam int OUT_W = ((ohrr_pkg::ERR_W + ohrr_pkg::NAV_W + CNT_W + 1 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // cmd, left wheel rpm, right wheel rpm, yaw (lowest bits first), zero padded
  input  logic [ohrr_pkg::IN_W-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // heading_error, nav_state, point_count, replay_done (lowest bits first)
  output logic [OUT_W-1:0]                  out_tdata,
  input  logic                              cfg_we,
  input  logic [ohrr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ohrr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ohrr_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic [STEP_W-1:0] step_r;
  logic              item_valid;
  logic              item_ready;
  odo_item_t         item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MILEAGE_GAIN:  gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_STEP_DISTANCE: step_r <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ohrr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .gain       (gain_r),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  ohrr_core #(
    .RECORD_DEPTH (RECORD_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .step       (step_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef ASSERT_OFF
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[ERR_W-1:0]) >= -16'sd17999 &&
                    $signed(out_tdata[ERR_W-1:0]) <= 16'sd18000))
    else $error("heading error outside wrapped range");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ERR_W+NAV_W +: CNT_W] <= CNT_W'(RECORD_DEPTH))
    else $error("point count above store depth");

  a_done_has_points: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[ERR_W+NAV_W+CNT_W]) |->
      out_tdata[ERR_W+NAV_W +: CNT_W] != '0)
    else $error("replay done with no stored points");
`endif

endmodule
